FILE: rtl/pfr_pkg.sv
// Shared types and constants for the PNG filter reconstruction block.
package pfr_pkg;

   localparam int FILTER_W   = 3;
   localparam int CHAN_W     = 8;
   localparam int NUM_CHAN   = 4;
   localparam int WIDTH_W    = 13;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   // Reset value of the image width register.
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd4096;

   // Register addresses on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH = 2'd0;

   // Filter type codes; anything else passes the pixel through unchanged.
   localparam logic [FILTER_W-1:0] FILT_NONE  = 3'd0;
   localparam logic [FILTER_W-1:0] FILT_SUB   = 3'd1;
   localparam logic [FILTER_W-1:0] FILT_UP    = 3'd2;
   localparam logic [FILTER_W-1:0] FILT_AVG   = 3'd3;
   localparam logic [FILTER_W-1:0] FILT_PAETH = 3'd4;

   typedef logic [CHAN_W-1:0] chan_type;
   // Channel 0 is red in the low byte, channel 3 is alpha in the high byte.
   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_type;

endpackage

FILE: rtl/pfr_req_if.sv
// Input channel: one filtered RGBA8 pixel per beat.
interface pfr_req_if;
   logic                          valid;
   logic                          ready;
   logic [pfr_pkg::FILTER_W-1:0]  filter_type;
   logic [pfr_pkg::CHAN_W-1:0]    filtered_red;
   logic [pfr_pkg::CHAN_W-1:0]    filtered_green;
   logic [pfr_pkg::CHAN_W-1:0]    filtered_blue;
   logic [pfr_pkg::CHAN_W-1:0]    filtered_alpha;
   logic                          start_of_image;

   modport source (
      output valid, filter_type, filtered_red, filtered_green, filtered_blue,
             filtered_alpha, start_of_image,
      input  ready
   );
   modport sink (
      input  valid, filter_type, filtered_red, filtered_green, filtered_blue,
             filtered_alpha, start_of_image,
      output ready
   );
endinterface

FILE: rtl/pfr_rsp_if.sv
// Result channel: one reconstructed RGBA8 pixel per beat.
interface pfr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pfr_pkg::CHAN_W-1:0]  out_red;
   logic [pfr_pkg::CHAN_W-1:0]  out_green;
   logic [pfr_pkg::CHAN_W-1:0]  out_blue;
   logic [pfr_pkg::CHAN_W-1:0]  out_alpha;
   logic                        end_of_row;

   modport source (
      output valid, out_red, out_green, out_blue, out_alpha, end_of_row,
      input  ready
   );
   modport sink (
      input  valid, out_red, out_green, out_blue, out_alpha, end_of_row,
      output ready
   );
endinterface

FILE: rtl/pfr_ram.sv
// Generic single-write, single-read RAM with registered, write-first read data.
module pfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // A read of the entry being written returns the new data.
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/pfr_predict.sv
// Per-channel predictor and modulo-256 reconstruction adder.
module pfr_predict (
   input  logic [pfr_pkg::FILTER_W-1:0] kind,
   input  pfr_pkg::chan_type            left,
   input  pfr_pkg::chan_type            up,
   input  pfr_pkg::chan_type            up_left,
   input  pfr_pkg::chan_type            filtered,
   output pfr_pkg::chan_type            recon
);
   import pfr_pkg::*;

   logic              [CHAN_W:0]   sum_ab;
   logic signed       [CHAN_W+1:0] dist_a;
   logic signed       [CHAN_W+1:0] dist_b;
   logic signed       [CHAN_W+1:0] dist_c;
   logic              [CHAN_W+1:0] mag_a;
   logic              [CHAN_W+1:0] mag_b;
   logic              [CHAN_W+1:0] mag_c;
   chan_type                       paeth;
   chan_type                       pred;

   // With p = a + b - c: p - a = b - c, p - b = a - c, p - c = a + b - 2c.
   assign sum_ab = {1'b0, left} + {1'b0, up};
   assign dist_a = signed'({2'b00, up})   - signed'({2'b00, up_left});
   assign dist_b = signed'({2'b00, left}) - signed'({2'b00, up_left});
   assign dist_c = signed'({1'b0, sum_ab}) - signed'({1'b0, up_left, 1'b0});

   assign mag_a = (dist_a < 0) ? unsigned'(-dist_a) : unsigned'(dist_a);
   assign mag_b = (dist_b < 0) ? unsigned'(-dist_b) : unsigned'(dist_b);
   assign mag_c = (dist_c < 0) ? unsigned'(-dist_c) : unsigned'(dist_c);

   always_comb begin
      if ((mag_a <= mag_b) && (mag_a <= mag_c)) begin
         paeth = left;
      end else if (mag_b <= mag_c) begin
         paeth = up;
      end else begin
         paeth = up_left;
      end
   end

   always_comb begin
      case (kind)
         FILT_NONE:  pred = '0;
         FILT_SUB:   pred = left;
         FILT_UP:    pred = up;
         FILT_AVG:   pred = sum_ab[CHAN_W:1];
         FILT_PAETH: pred = paeth;
         default:    pred = '0;
      endcase
   end

   assign recon = filtered + pred;
endmodule

FILE: rtl/png_filter_reconstruct_rgba8.sv
// PNG scanline filter reconstruction for RGBA8 pixels. Filtered pixels
// arrive in raster order on the req channel, each tagged with its own filter
// type (none, sub, up, average, Paeth; other codes pass the pixel through),
// and every input beat yields exactly one reconstructed pixel on the rsp
// channel, flagged with end_of_row on the last pixel of each row. A beat
// with start_of_image set begins a new image at the top-left pixel. The row
// length comes from the image_width register at byte address 0 of the APB
// port; a value of 0 acts as 1 and a value above MAX_WIDTH acts as MAX_WIDTH.
// Write the width only while the block is idle. The block sustains one
// pixel per clock: a beat is taken in every cycle in which the result path
// is not stalled, and an accepted beat passes through the input register
// and then the result register. The cycle time is set by the left-pixel
// feedback, which runs combinationally through the Paeth selection and the
// reconstruction adder. The previous row lives in a MAX_WIDTH-deep line
// buffer RAM; it needs no clearing after reset because the first row of an
// image never reads it.
module png_filter_reconstruct_rgba8 #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   pfr_req_if.sink                            req,
   pfr_rsp_if.source                          rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pfr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pfr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pfr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import pfr_pkg::*;

   // Column counter width and a compare width that holds both the column
   // and the configured width.
   localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CmpW = ((ColW > WIDTH_W) ? ColW : WIDTH_W) + 1;

   // Configuration register.
   logic [WIDTH_W-1:0] width_ff;
   logic               csr_write;

   // Input register stage.
   logic               s1_valid_ff;
   logic [FILTER_W-1:0] s1_kind_ff;
   pixel_type          s1_pix_ff;
   logic               s1_soi_ff;
   logic               s1_fire;

   // Row tracking state.
   logic [ColW-1:0]    col_ff;
   logic [ColW-1:0]    col_in;
   logic               first_ff;
   logic               first_in;
   pixel_type          left_ff;
   pixel_type          left_in;
   pixel_type          upleft_ff;
   pixel_type          upleft_in;

   // Result register.
   logic               rsp_valid_ff;
   pixel_type          rsp_pix_ff;
   logic               rsp_eor_ff;

   // Working signals for the item in the input register.
   logic [ColW-1:0]    col_use;
   logic               first_use;
   pixel_type          left_use;
   pixel_type          upleft_use;
   pixel_type          above;
   pixel_type          line_rd;
   pixel_type          recon;
   logic [CmpW-1:0]    width_wide;
   logic [CmpW-1:0]    width_eff;
   logic               last;

   // ---------------------------------------------------------------------
   // Configuration port. Writes complete in the access phase; pready is
   // tied high so every transfer finishes without wait states.
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == CSR_IMAGE_WIDTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_write) begin
         width_ff <= csr_pwdata[WIDTH_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr == CSR_IMAGE_WIDTH) begin
         csr_prdata = {{(CSR_DATA_W - WIDTH_W){1'b0}}, width_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   // ---------------------------------------------------------------------
   // Handshake. The input register takes a new beat whenever it is empty or
   // its item moves into the result register in the same cycle, and the
   // result register frees itself whenever the consumer takes its beat.
   // ---------------------------------------------------------------------
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         s1_kind_ff <= req.filter_type;
         s1_pix_ff  <= {req.filtered_alpha, req.filtered_blue,
                        req.filtered_green, req.filtered_red};
         s1_soi_ff  <= req.start_of_image;
      end
   end

   // ---------------------------------------------------------------------
   // Neighbor selection. A start-of-image beat restarts at column zero of
   // a first row with empty left and upper-left neighbors. On a first row
   // the line buffer is ignored and the pixels above count as zero.
   // ---------------------------------------------------------------------
   assign col_use    = s1_soi_ff ? '0 : col_ff;
   assign first_use  = s1_soi_ff || first_ff;
   assign left_use   = s1_soi_ff ? '0 : left_ff;
   assign upleft_use = s1_soi_ff ? '0 : upleft_ff;
   assign above      = first_use ? '0 : line_rd;

   for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_chan
      pfr_predict u_predict (
         .kind     (s1_kind_ff),
         .left     (left_use[ch]),
         .up       (above[ch]),
         .up_left  (upleft_use[ch]),
         .filtered (s1_pix_ff[ch]),
         .recon    (recon[ch])
      );
   end

   // Effective row length, clamped to the range 1..MAX_WIDTH. A column at
   // or past the last one ends the row, which also covers a width lowered
   // in the middle of a row.
   assign width_wide = CmpW'(width_ff);

   always_comb begin
      if (width_ff == '0) begin
         width_eff = CmpW'(1);
      end else if (width_wide > CmpW'(MAX_WIDTH)) begin
         width_eff = CmpW'(MAX_WIDTH);
      end else begin
         width_eff = width_wide;
      end
   end

   assign last = CmpW'(col_use) >= (width_eff - CmpW'(1));

   // ---------------------------------------------------------------------
   // Row tracking. After the last pixel of a row the column wraps, the
   // first-row flag drops, and both left neighbors return to zero.
   // ---------------------------------------------------------------------
   always_comb begin
      col_in    = col_ff;
      first_in  = first_ff;
      left_in   = left_ff;
      upleft_in = upleft_ff;
      if (s1_fire) begin
         if (last) begin
            col_in    = '0;
            first_in  = 1'b0;
            left_in   = '0;
            upleft_in = '0;
         end else begin
            col_in    = col_use + ColW'(1);
            first_in  = first_use;
            left_in   = recon;
            upleft_in = above;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         first_ff  <= 1'b1;
         left_ff   <= '0;
         upleft_ff <= '0;
      end else begin
         col_ff    <= col_in;
         first_ff  <= first_in;
         left_ff   <= left_in;
         upleft_ff <= upleft_in;
      end
   end

   // ---------------------------------------------------------------------
   // Line buffer. The read address is the column that the next pixel will
   // use, so its registered data lines up with col_ff in the following cycle. The
   // RAM forwards a same-cycle write, which covers a one-pixel-wide image.
   // ---------------------------------------------------------------------
   pfr_ram #(
      .WIDTH (NUM_CHAN * CHAN_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (col_use),
      .wr_data (recon),
      .rd_addr (col_in),
      .rd_data (line_rd)
   );

   // ---------------------------------------------------------------------
   // Result register.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_pix_ff <= recon;
         rsp_eor_ff <= last;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_red    = rsp_pix_ff[0];
   assign rsp.out_green  = rsp_pix_ff[1];
   assign rsp.out_blue   = rsp_pix_ff[2];
   assign rsp.out_alpha  = rsp_pix_ff[3];
   assign rsp.end_of_row = rsp_eor_ff;
endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the RGBA8 PNG filter reconstruction block.
module tb;
   import pfr_pkg::*;

   localparam int LINE_DEPTH = 4096;

   // The package names only the five defined filter types. The remaining codes
   // must pass the pixel through, so the tests sweep this range too.
   localparam logic [FILTER_W-1:0] FILT_UNUSED_LO = 3'd5;
   localparam logic [FILTER_W-1:0] FILT_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [FILTER_W-1:0] kind;
      pixel_type           data;
      logic                start_of_image;
   } pixel_beat_type;

   typedef struct packed {
      pixel_type pixel;
      logic      end_of_row;
   } result_beat_type;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pfr_req_if req_bus ();
   pfr_rsp_if rsp_bus ();

   png_filter_reconstruct_rgba8 #(
      .MAX_WIDTH (LINE_DEPTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Stimulus and scoreboard storage. Pixels wait in pending_beats until the
   // driver puts them on the bus; each accepted beat adds its reconstructed
   // pixel to expected_pixels, which the result checker drains in order.
   pixel_beat_type  pending_beats[$];
   result_beat_type expected_pixels[$];
   int              unaccepted_beats = 0;
   bit              mismatch_seen = 1'b0;

   // Image width as last written; shared by the predictor and the generator.
   logic [WIDTH_W-1:0] width_reg = WIDTH_RESET;

   // Predictor state: the reconstructed previous row, the left and upper-left
   // neighbors, and the raster position within the current image.
   pixel_type   line_store [LINE_DEPTH];
   pixel_type   left_pix = '0;
   pixel_type   upleft_pix = '0;
   int unsigned rec_col = 0;
   bit          rec_first = 1'b1;

   // The generator tracks the raster position of the pixels it has queued so
   // far, and which line store entries they wrote. The store holds garbage
   // after reset, so no pixel may read an entry that no earlier pixel wrote.
   int unsigned gen_col = 0;
   bit          gen_first = 1'b1;
   bit          gen_written [LINE_DEPTH];

   // Sender burst and gap counters, receiver stall pattern.
   int burst_left = 1;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_span = 0;

   // A zero width behaves as one pixel per row, and anything beyond the line
   // store depth is clamped to it.
   function automatic int unsigned effective_width();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
   endfunction

   // Paeth picks whichever of left, up or upper-left lies closest to
   // left + up - upper-left. Ties go to left first, then to up.
   function automatic chan_type paeth_pick(chan_type a, chan_type b, chan_type c);
      int dist_a;
      int dist_b;
      int dist_c;
      dist_a = int'(b) - int'(c);
      dist_b = int'(a) - int'(c);
      dist_c = int'(a) + int'(b) - 2 * int'(c);
      if (dist_a < 0) dist_a = -dist_a;
      if (dist_b < 0) dist_b = -dist_b;
      if (dist_c < 0) dist_c = -dist_c;
      if (dist_a <= dist_b && dist_a <= dist_c) return a;
      if (dist_b <= dist_c) return b;
      return c;
   endfunction

   function automatic chan_type channel_predictor(logic [FILTER_W-1:0] kind,
                                                  chan_type a, chan_type b,
                                                  chan_type c);
      logic [CHAN_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      case (kind)
         FILT_SUB:   return a;
         FILT_UP:    return b;
         FILT_AVG:   return sum[CHAN_W:1];
         FILT_PAETH: return paeth_pick(a, b, c);
         default:    return '0;
      endcase
   endfunction

   // Reconstructs one accepted pixel and advances the raster position.
   function automatic result_beat_type reconstruct_pixel(pixel_beat_type beat);
      pixel_type       above;
      pixel_type       recon;
      result_beat_type res;
      if (beat.start_of_image) begin
         rec_col    = 0;
         rec_first  = 1'b1;
         left_pix   = '0;
         upleft_pix = '0;
      end
      above = rec_first ? pixel_type'('0) : line_store[rec_col];
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         recon[ch] = beat.data[ch] +
                     channel_predictor(beat.kind, left_pix[ch], above[ch], upleft_pix[ch]);
      end
      res.pixel      = recon;
      // A column past the end also closes the row, which covers a width that
      // was lowered while a row was under way.
      res.end_of_row = (rec_col >= effective_width() - 1);
      line_store[rec_col] = recon;
      if (res.end_of_row) begin
         rec_col    = 0;
         rec_first  = 1'b0;
         left_pix   = '0;
         upleft_pix = '0;
      end else begin
         rec_col    = rec_col + 1;
         left_pix   = recon;
         upleft_pix = above;
      end
      return res;
   endfunction

   // Queues one pixel. A start of image is forced whenever the pixel would
   // otherwise read a line store entry that has never been written.
   task automatic queue_pixel(logic [FILTER_W-1:0] kind, pixel_type data, bit sof);
      pixel_beat_type beat;
      if (!gen_first && !gen_written[gen_col]) sof = 1'b1;
      if (sof) begin
         gen_col   = 0;
         gen_first = 1'b1;
      end
      gen_written[gen_col] = 1'b1;
      if (gen_col >= effective_width() - 1) begin
         gen_col   = 0;
         gen_first = 1'b0;
      end else begin
         gen_col = gen_col + 1;
      end
      beat.kind           = kind;
      beat.data           = data;
      beat.start_of_image = sof;
      pending_beats.push_back(beat);
      unaccepted_beats++;
   endtask

   // Random pixels, mostly whole images in raster order. With noise allowed,
   // a new image begins now and then at a row start and rarely mid-row.
   task automatic queue_random_pixels(int count, bit start_fresh, bit allow_noise);
      logic [FILTER_W-1:0] kind;
      pixel_type           data;
      bit                  sof;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 15) == 0)
            kind = FILTER_W'($urandom_range(FILT_UNUSED_LO, FILT_UNUSED_HI));
         else
            kind = FILTER_W'($urandom_range(FILT_NONE, FILT_PAETH));
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            case ($urandom_range(0, 7))
               0:       data[ch] = 8'h00;
               1:       data[ch] = 8'hff;
               default: data[ch] = CHAN_W'($urandom);
            endcase
         end
         sof = (i == 0 && start_fresh) ||
               (allow_noise && ((gen_col == 0 && $urandom_range(0, 9) == 0) ||
                                $urandom_range(0, 79) == 0));
         queue_pixel(kind, data, sof);
      end
   endtask

   // One APB write: a setup phase, then the access phase, which completes at
   // the first edge that sees pready high.
   task automatic write_image_width(logic [WIDTH_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_IMAGE_WIDTH;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      width_reg = value;
   endtask

   // Waits for every queued pixel to be accepted and checked, then lets the
   // two-stage pipeline settle before the width may change.
   task automatic wait_until_idle();
      while (unaccepted_beats != 0 || expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void compare_field(string field, int unsigned want,
                                         int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
         mismatch_seen = 1'b1;
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Driver. A beat that is not taken stays on the bus unchanged. Otherwise
   // the next pixel goes out unless the sender is in a gap between bursts.
   always @(posedge clock) begin : drive_pixels
      pixel_beat_type taken;
      pixel_beat_type next_beat;
      if (reset) begin
         req_bus.valid          <= 1'b0;
         req_bus.filter_type    <= FILT_NONE;
         req_bus.filtered_red   <= '0;
         req_bus.filtered_green <= '0;
         req_bus.filtered_blue  <= '0;
         req_bus.filtered_alpha <= '0;
         req_bus.start_of_image <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            taken.kind           = req_bus.filter_type;
            taken.data           = {req_bus.filtered_alpha, req_bus.filtered_blue,
                                    req_bus.filtered_green, req_bus.filtered_red};
            taken.start_of_image = req_bus.start_of_image;
            expected_pixels.push_back(reconstruct_pixel(taken));
            unaccepted_beats--;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               next_beat = pending_beats.pop_front();
               req_bus.filter_type    <= next_beat.kind;
               req_bus.filtered_red   <= next_beat.data[0];
               req_bus.filtered_green <= next_beat.data[1];
               req_bus.filtered_blue  <= next_beat.data[2];
               req_bus.filtered_alpha <= next_beat.data[3];
               req_bus.start_of_image <= next_beat.start_of_image;
               req_bus.valid          <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  // About a quarter of the bursts run straight into the next.
                  burst_left = $urandom_range(1, 24);
                  case ($urandom_range(0, 3))
                     0:       gap_left = 0;
                     3:       gap_left = $urandom_range(4, 12);
                     default: gap_left = $urandom_range(1, 3);
                  endcase
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result checker and receiver backpressure. Every result beat is matched
   // against the oldest outstanding prediction. The ready pattern switches
   // among always ready, light and heavy random stalls, and alternation.
   always @(posedge clock) begin : check_results
      result_beat_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: result beat with no pixel outstanding, actual 0x%0h eor %0b",
                        $time, {rsp_bus.out_alpha, rsp_bus.out_blue, rsp_bus.out_green,
                                rsp_bus.out_red}, rsp_bus.end_of_row);
               mismatch_seen = 1'b1;
            end else begin
               want = expected_pixels.pop_front();
               compare_field("out_red",    want.pixel[0],  rsp_bus.out_red);
               compare_field("out_green",  want.pixel[1],  rsp_bus.out_green);
               compare_field("out_blue",   want.pixel[2],  rsp_bus.out_blue);
               compare_field("out_alpha",  want.pixel[3],  rsp_bus.out_alpha);
               compare_field("end_of_row", want.end_of_row, rsp_bus.end_of_row);
            end
         end
         if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(16, 128);
         end else begin
            stall_span--;
         end
         case (stall_mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
            2:       rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            default: rsp_bus.ready <= ~rsp_bus.ready;
         endcase
      end
   end

   initial begin
      int unsigned new_width;
      reset                  = 1'b1;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;
      foreach (gen_written[i]) gen_written[i] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Three pixels on the first row at the reset width.
      queue_pixel(FILT_NONE,  32'hff7f8000, 1'b1);
      queue_pixel(FILT_SUB,   32'hffffffff, 1'b0);
      queue_pixel(FILT_PAETH, 32'h01fe807f, 1'b0);
      wait_until_idle();

      // Dropping the width to 3 mid-row makes the next pixel, at column 3,
      // close the row. The rows after it read back what was just written.
      write_image_width(13'd3);
      queue_pixel(FILT_NONE,  32'h007f80ff, 1'b0);
      queue_pixel(FILT_UP,    32'h00000000, 1'b0);
      queue_pixel(FILT_AVG,   32'hffffffff, 1'b0);
      queue_pixel(FILT_PAETH, 32'h7f80fe01, 1'b0);
      queue_pixel(FILT_SUB,   32'hffffffff, 1'b0);
      queue_pixel(FILT_PAETH, 32'h00000000, 1'b0);
      queue_pixel(FILT_AVG,   32'h80808080, 1'b0);
      for (int k = FILT_UNUSED_LO; k <= FILT_UNUSED_HI; k++)
         queue_pixel(FILTER_W'(k), 32'hffffffff, 1'b0);
      // A new image starting mid-row: every neighbor must read as zero again.
      queue_pixel(FILT_UP,    32'h78563412, 1'b1);
      queue_pixel(FILT_SUB,   32'hffffffff, 1'b0);
      queue_pixel(FILT_PAETH, pixel_type'($urandom), 1'b0);
      queue_pixel(FILT_PAETH, 32'hffffffff, 1'b0);
      queue_pixel(FILT_PAETH, 32'h00000000, 1'b0);
      queue_pixel(FILT_UP,    32'hffffffff, 1'b0);
      queue_pixel(FILT_AVG,   32'h00000000, 1'b0);
      queue_pixel(FILT_SUB,   32'h00000000, 1'b0);
      queue_pixel(FILT_NONE,  32'hffffffff, 1'b0);
      wait_until_idle();

      // Degenerate widths: zero acts as one pixel per row.
      write_image_width(13'd0);
      queue_random_pixels(50, 1'b1, 1'b1);
      wait_until_idle();
      write_image_width(13'd1);
      queue_random_pixels(50, 1'b1, 1'b1);
      wait_until_idle();
      write_image_width(13'd2);
      queue_random_pixels(60, 1'b1, 1'b1);
      wait_until_idle();

      // The largest field value clamps to the line store depth, so a long
      // first row runs on without a row end.
      write_image_width(13'h1fff);
      queue_random_pixels(300, 1'b1, 1'b0);
      wait_until_idle();

      // The width shrinks while the first row is under way.
      write_image_width(13'd10);
      queue_random_pixels(100, 1'b0, 1'b1);
      wait_until_idle();

      repeat (11) begin
         case ($urandom_range(0, 9))
            0:       new_width = LINE_DEPTH;
            1:       new_width = $urandom_range(100, 400);
            default: new_width = $urandom_range(1, 48);
         endcase
         write_image_width(WIDTH_W'(new_width));
         queue_random_pixels(80, 1'($urandom_range(0, 1)), 1'b1);
         wait_until_idle();
      end

      write_image_width(WIDTH_RESET);
      queue_random_pixels(60, 1'b1, 1'b1);
      wait_until_idle();

      repeat (8) @(posedge clock);
      if (!mismatch_seen)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog: ends the run as failed if it has not finished by this time limit.
   initial begin
      #4_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
